/* hdl/alarm_clock_seven_segment_mux_macros.svh */
// assertion macros for the alarm clock display block
`ifndef ALARM_CLOCK_SEVEN_SEGMENT_MUX_MACROS_SVH
`define ALARM_CLOCK_SEVEN_SEGMENT_MUX_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/acssm_pkg.sv */
package acssm_pkg;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_TICKS_PER_MINUTE    = 3'd0;
  localparam cfg_index_t REG_ALARM_HOUR          = 3'd1;
  localparam cfg_index_t REG_ALARM_MINUTE        = 3'd2;
  localparam cfg_index_t REG_BUZZ_DURATION_TICKS = 3'd3;
  localparam cfg_index_t REG_BUZZ_TOGGLE_TICKS   = 3'd4;

  localparam logic [23:0] TICKS_PER_MINUTE_RESET    = 24'd22980;
  localparam logic [4:0]  ALARM_HOUR_RESET          = 5'd5;
  localparam logic [5:0]  ALARM_MINUTE_RESET        = 6'd30;
  localparam logic [23:0] BUZZ_DURATION_TICKS_RESET = 24'd3830;
  localparam logic [15:0] BUZZ_TOGGLE_TICKS_RESET   = 16'd0;

  localparam logic [4:0] NOON_HOUR = 5'd12;

  typedef struct packed {
    logic [3:0] minute_units;
    logic [2:0] minute_tens;
    logic [3:0] hour_units;
    logic [1:0] hour_tens;
    logic       mode_twentyfour;
  } clock_state_t;

  function automatic logic [4:0] hour24(input clock_state_t t);
    return 5'(t.hour_tens) * 5'd10 + 5'(t.hour_units);
  endfunction

  function automatic logic [5:0] minute60(input clock_state_t t);
    return 6'(t.minute_tens) * 6'd10 + 6'(t.minute_units);
  endfunction

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* hdl/acssm_clock.sv */
module acssm_clock #(
  parameter int TICK_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  button_pressed,
  input  logic [23:0]           minute_len,
  output acssm_pkg::clock_state_t state_next
);
  import acssm_pkg::*;

  localparam int CMP_W = (TICK_WIDTH + 1 > 24) ? TICK_WIDTH + 1 : 24;

  logic [TICK_WIDTH-1:0] tick_count;
  logic [TICK_WIDTH-1:0] tick_count_next;
  logic [TICK_WIDTH:0]   tick_plus;
  logic                  minute_done;
  logic                  button_last;
  clock_state_t          state;

  assign tick_plus   = {1'b0, tick_count} + {{TICK_WIDTH{1'b0}}, 1'b1};
  assign minute_done = CMP_W'(tick_plus) >= CMP_W'(minute_len);
  assign tick_count_next = minute_done ? '0 : tick_plus[TICK_WIDTH-1:0];

  always_comb begin
    state_next = state;
    state_next.mode_twentyfour = state.mode_twentyfour ^ (button_pressed & ~button_last);
    if (minute_done) begin
      if (state.minute_units >= 4'd9) begin
        state_next.minute_units = 4'd0;
        if (state.minute_tens >= 3'd5) begin
          state_next.minute_tens = 3'd0;
          if (state.hour_units >= 4'd9) begin
            state_next.hour_units = 4'd0;
            state_next.hour_tens  = state.hour_tens + 2'd1;
          end else begin
            state_next.hour_units = state.hour_units + 4'd1;
          end
          if (state.hour_tens == 2'd2 && state.hour_units == 4'd3) begin
            state_next.hour_tens  = 2'd0;
            state_next.hour_units = 4'd0;
          end
        end else begin
          state_next.minute_tens = state.minute_tens + 3'd1;
        end
      end else begin
        state_next.minute_units = state.minute_units + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      button_last <= 1'b1;
      state       <= '{minute_units: 4'd0, minute_tens: 3'd0, hour_units: 4'd0,
                       hour_tens: 2'd0, mode_twentyfour: 1'b1};
    end else if (advance) begin
      tick_count  <= tick_count_next;
      button_last <= button_pressed;
      state       <= state_next;
    end
  end

endmodule

/* hdl/acssm_buzzer.sv */
module acssm_buzzer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  acssm_pkg::clock_state_t time_next,
  input  logic [4:0]              alarm_hr,
  input  logic [5:0]              alarm_minute,
  input  logic [23:0]             buzz_duration_ticks,
  input  logic [15:0]             buzz_toggle_ticks,
  output logic                    buzz_level_next
);
  import acssm_pkg::*;

  logic        buzz_active;
  logic [23:0] buzz_remaining;
  logic [15:0] buzz_phase_count;
  logic        buzz_level;

  logic        trigger;
  logic        act;
  logic [23:0] rem;
  logic [15:0] phase_inc;
  logic        buzz_active_next;
  logic [23:0] buzz_remaining_next;
  logic [15:0] buzz_phase_count_next;

  assign trigger = (hour24(time_next) == alarm_hr) && (minute60(time_next) == alarm_minute)
                   && !buzz_active;
  assign act       = buzz_active | trigger;
  assign rem       = trigger ? buzz_duration_ticks : buzz_remaining;
  assign phase_inc = (trigger ? 16'd0 : buzz_phase_count) + 16'd1;

  always_comb begin
    buzz_active_next      = buzz_active;
    buzz_remaining_next   = buzz_remaining;
    buzz_phase_count_next = buzz_phase_count;
    buzz_level_next       = 1'b0;
    if (act) begin
      if (phase_inc >= buzz_toggle_ticks) begin
        buzz_phase_count_next = 16'd0;
        buzz_level_next       = ~buzz_level;
      end else begin
        buzz_phase_count_next = phase_inc;
        buzz_level_next       = buzz_level;
      end
      if (rem <= 24'd1) begin
        buzz_remaining_next = 24'd0;
        buzz_active_next    = 1'b0;
        buzz_level_next     = 1'b0;
      end else begin
        buzz_remaining_next = rem - 24'd1;
        buzz_active_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buzz_active      <= 1'b0;
      buzz_remaining   <= 24'd0;
      buzz_phase_count <= 16'd0;
      buzz_level       <= 1'b0;
    end else if (advance) begin
      buzz_active      <= buzz_active_next;
      buzz_remaining   <= buzz_remaining_next;
      buzz_phase_count <= buzz_phase_count_next;
      buzz_level       <= buzz_level_next;
    end
  end

endmodule

/* hdl/acssm_display.sv */
module acssm_display (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  acssm_pkg::clock_state_t time_next,
  output logic [6:0]              segments_next,
  output logic [3:0]              digit_select_next,
  output logic                    am_led_next
);
  import acssm_pkg::*;

  logic [1:0] mux_index;
  logic [4:0] h24;
  logic [4:0] disp_h;
  logic [1:0] hour_tens_disp;
  logic [3:0] hour_units_disp;
  logic [3:0] digit;

  assign h24         = hour24(time_next);
  assign am_led_next = h24 < NOON_HOUR;

  always_comb begin
    disp_h = h24;
    if (!time_next.mode_twentyfour) begin
      if (h24 == 5'd0) begin
        disp_h = NOON_HOUR;
      end else if (h24 > NOON_HOUR) begin
        disp_h = h24 - NOON_HOUR;
      end
    end
    if (disp_h >= 5'd20) begin
      hour_tens_disp  = 2'd2;
      hour_units_disp = 4'(disp_h - 5'd20);
    end else if (disp_h >= 5'd10) begin
      hour_tens_disp  = 2'd1;
      hour_units_disp = 4'(disp_h - 5'd10);
    end else begin
      hour_tens_disp  = 2'd0;
      hour_units_disp = 4'(disp_h);
    end
    case (mux_index)
      2'd0:    digit = time_next.minute_units;
      2'd1:    digit = {1'b0, time_next.minute_tens};
      2'd2:    digit = hour_units_disp;
      default: digit = {2'b00, hour_tens_disp};
    endcase
  end

  assign segments_next     = seg_of(digit);
  assign digit_select_next = 4'b0001 << mux_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_index <= 2'd0;
    end else if (advance) begin
      mux_index <= mux_index + 2'd1;
    end
  end

endmodule

/* hdl/alarm_clock_seven_segment_mux.sv */
// path: an accepted item passes the input register, then the result register
// throughput: one item per cycle while the result is not stalled, set by the input register and the result register
// a stalled result holds the pipe; an empty input register still takes a new item
// reset: synchronous, clears both stages, sets time 00:00 in 24-hour form,
// buzzer idle, digit rotation at minute units, registers to their defaults
module alarm_clock_seven_segment_mux #(
  parameter int TICK_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        button_pressed,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [6:0]  segments,
  output logic [3:0]  digit_select,
  output logic        am_led,
  output logic        buzzer,
  input  logic        cfg_write,
  input  acssm_pkg::cfg_index_t cfg_index,
  input  logic [23:0] cfg_data
);
  import acssm_pkg::*;
  `include "alarm_clock_seven_segment_mux_macros.svh"

  logic [23:0] minute_len;
  logic [4:0]  alarm_hr;
  logic [5:0]  alarm_minute;
  logic [23:0] buzz_duration_ticks;
  logic [15:0] buzz_toggle_ticks;

  logic         s1_valid;
  logic         s1_button;
  logic         s1_move;
  clock_state_t time_next;
  logic         buzz_level_next;
  logic [6:0]   segments_next;
  logic [3:0]   digit_select_next;
  logic         am_led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_len          <= TICKS_PER_MINUTE_RESET;
      alarm_hr            <= ALARM_HOUR_RESET;
      alarm_minute        <= ALARM_MINUTE_RESET;
      buzz_duration_ticks <= BUZZ_DURATION_TICKS_RESET;
      buzz_toggle_ticks   <= BUZZ_TOGGLE_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TICKS_PER_MINUTE:    minute_len          <= cfg_data;
        REG_ALARM_HOUR:          alarm_hr            <= cfg_data[4:0];
        REG_ALARM_MINUTE:        alarm_minute        <= cfg_data[5:0];
        REG_BUZZ_DURATION_TICKS: buzz_duration_ticks <= cfg_data;
        REG_BUZZ_TOGGLE_TICKS:   buzz_toggle_ticks   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s1_move    = s1_valid && !(result_valid && result_stall);
  assign item_stall = s1_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_button <= button_pressed;
    end
  end

  acssm_clock #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_clock (
    .clk              (clk),
    .rst              (rst),
    .advance          (s1_move),
    .button_pressed   (s1_button),
    .minute_len       (minute_len),
    .state_next       (time_next)
  );

  acssm_buzzer u_buzzer (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (s1_move),
    .time_next           (time_next),
    .alarm_hr            (alarm_hr),
    .alarm_minute        (alarm_minute),
    .buzz_duration_ticks (buzz_duration_ticks),
    .buzz_toggle_ticks   (buzz_toggle_ticks),
    .buzz_level_next     (buzz_level_next)
  );

  acssm_display u_display (
    .clk               (clk),
    .rst               (rst),
    .advance           (s1_move),
    .time_next         (time_next),
    .segments_next     (segments_next),
    .digit_select_next (digit_select_next),
    .am_led_next       (am_led_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      segments     <= segments_next;
      digit_select <= digit_select_next;
      am_led       <= am_led_next;
      buzzer       <= buzz_level_next;
    end
  end

  `ASSERT_NEXT(a_move_fills_result, clk, rst, s1_move, result_valid)
  `ASSERT_IMPL(a_stall_needs_full_stage, clk, rst, item_stall, s1_valid && result_valid)
  `ASSERT_IMPL(a_digit_onehot, clk, rst, result_valid, $onehot(digit_select))
  `ASSERT_IMPL(a_time_bcd, clk, rst, s1_move, time_next.minute_units <= 4'd9 && time_next.hour_tens <= 2'd2)

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import acssm_pkg::*;

  localparam int PIPE_LATENCY = 2;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD_CYCLES = 50;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int MINUTES_PER_DAY = 1440;
  localparam logic [23:0] FULL_SCALE = '1;
  localparam logic [15:0] TOGGLE_MAX = '1;
  localparam logic [19:0] OPENING_LEVELS = 20'b1101_0011_1101_0111_0001;

  typedef struct packed {
    logic [6:0] segments;
    logic [3:0] digit_select;
    logic       am_led;
    logic       buzzer;
  } display_frame_t;

  class alarm_clock_scoreboard;
    logic [23:0] minute_len;
    logic [4:0]  alarm_hr;
    logic [5:0]  alarm_min;
    logic [23:0] buzz_len;
    logic [15:0] toggle_len;

    logic [23:0] tick_cnt;
    logic [3:0]  min_u;
    logic [2:0]  min_t;
    logic [3:0]  hr_u;
    logic [1:0]  hr_t;
    logic        show_24h;
    logic        level_prev;
    logic        buzzing;
    logic [23:0] buzz_left;
    logic [15:0] phase_cnt;
    logic        buzz_lvl;
    logic [1:0]  digit_idx;

    display_frame_t frames_due[$];
    int mismatch_count;

    function new();
      minute_len = TICKS_PER_MINUTE_RESET;
      alarm_hr = ALARM_HOUR_RESET;
      alarm_min = ALARM_MINUTE_RESET;
      buzz_len = BUZZ_DURATION_TICKS_RESET;
      toggle_len = BUZZ_TOGGLE_TICKS_RESET;
      tick_cnt = '0;
      min_u = '0;
      min_t = '0;
      hr_u = '0;
      hr_t = '0;
      show_24h = 1'b1;
      level_prev = 1'b1;
      buzzing = 1'b0;
      buzz_left = '0;
      phase_cnt = '0;
      buzz_lvl = 1'b0;
      digit_idx = '0;
      mismatch_count = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [23:0] data);
      case (idx)
        REG_TICKS_PER_MINUTE: minute_len = data;
        REG_ALARM_HOUR: alarm_hr = data[4:0];
        REG_ALARM_MINUTE: alarm_min = data[5:0];
        REG_BUZZ_DURATION_TICKS: buzz_len = data;
        REG_BUZZ_TOGGLE_TICKS: toggle_len = data[15:0];
        default: ;
      endcase
    endfunction

    function int minutes_now();
      return (int'(hr_t) * 10 + int'(hr_u)) * MINUTES_PER_HOUR + int'(min_t) * 10 + int'(min_u);
    endfunction

    function logic [6:0] glyph(int d);
      case (d)
        0: return 7'h3F;
        1: return 7'h06;
        2: return 7'h5B;
        3: return 7'h4F;
        4: return 7'h66;
        5: return 7'h6D;
        6: return 7'h7D;
        7: return 7'h07;
        8: return 7'h7F;
        9: return 7'h6F;
        default: return 7'h00;
      endcase
    endfunction

    // one multiplex tick: advance time, button edge, alarm, buzzer, digit
    function void take_tick(logic level);
      logic [24:0] next_count;
      int h24;
      int mins;
      int shown_h;
      int digit;
      display_frame_t f;
      next_count = {1'b0, tick_cnt} + 25'd1;
      if (next_count >= {1'b0, minute_len}) begin
        tick_cnt = '0;
        if (min_u == 4'd9) begin
          min_u = '0;
          if (min_t == 3'd5) begin
            min_t = '0;
            if (hr_u == 4'd9) begin
              hr_u = '0;
              hr_t = hr_t + 2'd1;
            end else begin
              hr_u = hr_u + 4'd1;
            end
            if (hr_t == 2'd2 && hr_u == 4'd4) begin
              hr_t = '0;
              hr_u = '0;
            end
          end else begin
            min_t = min_t + 3'd1;
          end
        end else begin
          min_u = min_u + 4'd1;
        end
      end else begin
        tick_cnt = next_count[23:0];
      end

      if (level && !level_prev) show_24h = !show_24h;
      level_prev = level;

      h24 = int'(hr_t) * 10 + int'(hr_u);
      mins = int'(min_t) * 10 + int'(min_u);
      f.am_led = (h24 < int'(NOON_HOUR));

      if (h24 == int'(alarm_hr) && mins == int'(alarm_min) && !buzzing) begin
        buzzing = 1'b1;
        buzz_left = buzz_len;
        phase_cnt = '0;
      end

      if (buzzing) begin
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= toggle_len) begin
          phase_cnt = '0;
          buzz_lvl = !buzz_lvl;
        end
        if (buzz_left <= 24'd1) begin
          buzz_left = '0;
          buzzing = 1'b0;
          buzz_lvl = 1'b0;
        end else begin
          buzz_left = buzz_left - 24'd1;
        end
      end else begin
        buzz_lvl = 1'b0;
      end

      shown_h = h24;
      if (!show_24h) begin
        if (shown_h == 0) shown_h = int'(NOON_HOUR);
        else if (shown_h > int'(NOON_HOUR)) shown_h = shown_h - int'(NOON_HOUR);
      end

      case (digit_idx)
        2'd0: digit = int'(min_u);
        2'd1: digit = int'(min_t);
        2'd2: digit = shown_h % 10;
        default: digit = shown_h / 10;
      endcase

      f.segments = glyph(digit);
      f.digit_select = 4'b0001 << digit_idx;
      f.buzzer = buzz_lvl;
      digit_idx = digit_idx + 2'd1;
      frames_due.push_back(f);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_frame(display_frame_t got);
      display_frame_t want;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction outstanding", got));
        return;
      end
      want = frames_due.pop_front();
      if (got.segments !== want.segments)
        report_mismatch($sformatf("segments %h, expected %h", got.segments, want.segments));
      if (got.digit_select !== want.digit_select)
        report_mismatch($sformatf("digit_select %b, expected %b",
                                  got.digit_select, want.digit_select));
      if (got.am_led !== want.am_led)
        report_mismatch($sformatf("am_led %b, expected %b", got.am_led, want.am_led));
      if (got.buzzer !== want.buzzer)
        report_mismatch($sformatf("buzzer %b, expected %b", got.buzzer, want.buzzer));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        button_pressed;
  logic        result_valid;
  logic        result_stall;
  logic [6:0]  segments;
  logic [3:0]  digit_select;
  logic        am_led;
  logic        buzzer;
  logic        cfg_write;
  cfg_index_t  cfg_index;
  logic [23:0] cfg_data;

  alarm_clock_scoreboard clock_sb;
  int cycle_count = 0;
  bit sender_gapless = 1'b0;
  bit steady_tail = 1'b0;
  bit long_hold_due = 1'b0;

  alarm_clock_seven_segment_mux u_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .button_pressed (button_pressed),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .segments       (segments),
    .digit_select   (digit_select),
    .am_led         (am_led),
    .buzzer         (buzzer),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // sample every transaction at the edge that accepts it
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) clock_sb.write_register(cfg_index, cfg_data);
      if (result_valid && !result_stall)
        clock_sb.check_frame({segments, digit_select, am_led, buzzer});
      if (item_valid && !item_stall) clock_sb.take_tick(button_pressed);
    end
  end

  initial begin : result_side
    int span;
    result_stall <= 1'b0;
    forever begin
      if (long_hold_due) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_due = 1'b0;
      end else if (!steady_tail && $urandom_range(3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        span = steady_tail ? 1 : $urandom_range(1, 20);
        repeat (span) @(posedge clk);
      end
    end
  end

  task automatic offer_item(logic level);
    int gap;
    gap = 0;
    if (!sender_gapless && !steady_tail && $urandom_range(4) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    button_pressed <= level;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic offer_random_items(int count);
    for (int n = 0; n < count; n++) offer_item(1'($urandom_range(1)));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (clock_sb.frames_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic poke_register(cfg_index_t idx, logic [23:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // negative lead puts the alarm out of range
  task automatic program_clock(logic [23:0] minute_ticks, int lead,
                               logic [23:0] buzz_ticks, logic [15:0] toggle_ticks);
    int target;
    logic [4:0] hr;
    logic [5:0] mn;
    target = (clock_sb.minutes_now() + ((lead > 0) ? lead : 0)) % MINUTES_PER_DAY;
    hr = 5'(target / MINUTES_PER_HOUR);
    mn = 6'(target % MINUTES_PER_HOUR);
    if (lead < 0) begin
      if ($urandom_range(1) == 1) hr = 5'($urandom_range(24, 31));
      else mn = 6'($urandom_range(60, 63));
    end
    poke_register(REG_TICKS_PER_MINUTE, minute_ticks);
    poke_register(REG_ALARM_HOUR, {19'($urandom()), hr});
    poke_register(REG_ALARM_MINUTE, {18'($urandom()), mn});
    poke_register(REG_BUZZ_DURATION_TICKS, buzz_ticks);
    poke_register(REG_BUZZ_TOGGLE_TICKS, {8'($urandom()), toggle_ticks});
  endtask

  initial begin : stimulus
    int count;
    int lead;
    logic [23:0] minute_ticks;
    logic [23:0] buzz_ticks;
    logic [15:0] toggle_ticks;
    clock_sb = new();
    rst <= 1'b1;
    item_valid <= 1'b0;
    button_pressed <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= REG_TICKS_PER_MINUTE;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default registers, button edges flip between 24 and 12 hour display
    for (int i = 0; i < $bits(OPENING_LEVELS); i++) offer_item(OPENING_LEVELS[i]);
    drain();

    // writes to unused indexes must be ignored
    for (int i = int'(REG_BUZZ_TOGGLE_TICKS) + 1; i <= int'(cfg_index_t'('1)); i++)
      poke_register(cfg_index_t'(i), 24'($urandom()));

    // zero minute length and zero buzz duration, alarm one minute ahead
    program_clock(24'd0, 1, 24'd0, 16'd0);
    offer_random_items(8);
    drain();

    for (int p = 0; p < 10; p++) begin
      count = $urandom_range(20, 40);
      case ($urandom_range(3))
        0: minute_ticks = 24'd0;
        1: minute_ticks = 24'd1;
        default: minute_ticks = 24'($urandom_range(2, 6));
      endcase
      if ($urandom_range(5) == 0)
        lead = -1;
      else
        lead = $urandom_range(0, count / ((minute_ticks > 1) ? int'(minute_ticks) : 1) / 2);
      case ($urandom_range(5))
        0: buzz_ticks = 24'd0;
        1: buzz_ticks = 24'($urandom_range(100, 300));
        default: buzz_ticks = 24'($urandom_range(1, 30));
      endcase
      case ($urandom_range(4))
        0: toggle_ticks = 16'd0;
        1: toggle_ticks = 16'd1;
        2: toggle_ticks = TOGGLE_MAX;
        default: toggle_ticks = 16'($urandom_range(2, 5));
      endcase
      program_clock(minute_ticks, lead, buzz_ticks, toggle_ticks);
      offer_random_items(count);
      drain();
    end

    // receiver holds off while items keep coming
    program_clock(24'($urandom_range(1, 4)), $urandom_range(0, 10), 24'd12, 16'd2);
    sender_gapless = 1'b1;
    long_hold_due = 1'b1;
    offer_random_items(50);
    sender_gapless = 1'b0;
    drain();

    // longest minute and buzz duration, no idling at all
    program_clock(FULL_SCALE, 0, FULL_SCALE, 16'($urandom_range(0, 3)));
    steady_tail = 1'b1;
    offer_random_items(30);
    drain();

    if (clock_sb.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
